// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Both expect clk_i and rst_ni in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define RCRS_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequence that must hold in the cycle after the trigger.
`define RCRS_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rcrs_pkg.sv =====
package rcrs_pkg;

  // Geometry limits and field widths
  localparam int MaxPanelDim = 4096;
  localparam int CoordW      = 16;
  localparam int DimW        = 12;
  localparam int RadW        = 11;
  localparam int AlphaW      = 8;

  // Square root datapath: radicand is r*r, root fits the radius width
  localparam int SqW        = 2 * RadW;
  localparam int SqrtStages = RadW;
  localparam int RemW       = RadW + 2;

  // Radius term floor(width / 20) as a multiply by a rounded-up reciprocal.
  // 20 * Recip exceeds 2^16 by 4, so the error stays below 1/20 for 12-bit widths.
  localparam int RadiusDivisor = 20;
  localparam int RecipShift    = 16;
  localparam int RadiusRecip   = ((1 << RecipShift) + RadiusDivisor - 1) / RadiusDivisor;
  localparam int RecipW        = 12;
  localparam int ProdW         = DimW + RecipW;
  localparam int QuotW         = ProdW - RecipShift;

  // Queue between front and back
  localparam int FqDepth = 4;
  localparam int FqPtrW  = $clog2(FqDepth);
  localparam int FqCntW  = $clog2(FqDepth + 1);

  // Result queue; its depth also bounds the requests in flight in the back end
  localparam int OutDepth = 32;
  localparam int OutPtrW  = $clog2(OutDepth);
  localparam int OutCntW  = $clog2(OutDepth + 1);

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = CoordW;

  typedef enum logic [CfgIdxW-1:0] {
    RegPanelLeft   = 3'd0,
    RegPanelTop    = 3'd1,
    RegPanelWidth  = 3'd2,
    RegPanelHeight = 3'd3,
    RegMinRadius   = 3'd4,
    RegDimAlpha    = 3'd5
  } cfg_reg_e;

  // Live configuration plus the derived corner radius
  typedef struct packed {
    logic [CoordW-1:0] panel_left;
    logic [CoordW-1:0] panel_top;
    logic [DimW-1:0]   panel_width;
    logic [DimW-1:0]   panel_height;
    logic [RadW-1:0]   radius;
    logic [AlphaW-1:0] dim_alpha;
  } cfg_t;

  // Classified row handed from front to back
  typedef struct packed {
    logic [CoordW-1:0] span_y;
    logic              band;
    logic [RadW-1:0]   dy;
  } fq_item_t;

  // Sideband riding along the square root pipeline
  typedef struct packed {
    logic [CoordW-1:0] span_y;
    logic              band;
  } sq_side_t;

  // Finished span
  typedef struct packed {
    logic [CoordW-1:0] span_x;
    logic [CoordW-1:0] span_y;
    logic [DimW-1:0]   span_width;
    logic [AlphaW-1:0] fill_alpha;
  } out_item_t;

  // Back end occupancy
  typedef struct packed {
    logic [OutCntW-1:0] credit;
    logic [OutCntW-1:0] out_count;
  } bk_status_t;

endpackage

// ===== rtl/core/rounded_corner_row_span.sv =====
// Row span generator for a rounded rectangle panel.
// Input channel: drive row_index_i with push_i; the request is taken at a clock
// edge where push_i is high and full_o is low. Rows at or past the panel height
// produce no result, nor do rows whose span comes out empty.
// Result channel: while empty_o is low the oldest span sits on span_x_o,
// span_y_o, span_width_o and fill_alpha_o; pop_i takes it at a clock edge.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (left, top, width, height, min radius, dim alpha); write only while idle.
// Path: front register, front queue, multiply and subtract stages, square root
// and result queue. Throughput: one request per cycle while not stalled, set by
// the 11-stage pipelined square root (one root bit per stage) and the multiply stage.
// Stalls: a pop_i held low fills the 32-entry result queue; the back end stops
// issuing once 32 requests are in flight or waiting, the 4-entry queue
// behind the front stage fills, and full_o rises.
// Reset: all queues empty, registers back to width 1, height 1, others 0.
`include "assert_macros.svh"

module rounded_corner_row_span (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rcrs_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [rcrs_pkg::CfgDataW-1:0]         cfg_wdata_i,
  input  logic                                  push_i,
  output logic                                  full_o,
  input  logic [rcrs_pkg::DimW-1:0]             row_index_i,
  output logic                                  empty_o,
  input  logic                                  pop_i,
  output logic signed [rcrs_pkg::CoordW-1:0]    span_x_o,
  output logic signed [rcrs_pkg::CoordW-1:0]    span_y_o,
  output logic [rcrs_pkg::DimW-1:0]             span_width_o,
  output logic [rcrs_pkg::AlphaW-1:0]           fill_alpha_o
);

  logic [rcrs_pkg::CoordW-1:0]   left_q, top_q;
  logic [rcrs_pkg::DimW-1:0]     width_q, height_q;
  logic [rcrs_pkg::RadW-1:0]     min_radius_q, radius_q, radius_d;
  logic [rcrs_pkg::AlphaW-1:0]   alpha_q;
  logic [rcrs_pkg::ProdW-1:0]    width_prod;
  logic [rcrs_pkg::RadW-1:0]     width_term;

  rcrs_pkg::cfg_t                cfg;
  rcrs_pkg::fq_item_t            fq_din, fq_dout;
  logic                          fq_push, fq_full, fq_pop, fq_empty;
  rcrs_pkg::out_item_t           out_item;
  rcrs_pkg::bk_status_t          bk_status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q       <= '0;
      top_q        <= '0;
      width_q      <= rcrs_pkg::DimW'(1);
      height_q     <= rcrs_pkg::DimW'(1);
      min_radius_q <= '0;
      alpha_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcrs_pkg::RegPanelLeft:   left_q       <= cfg_wdata_i;
        rcrs_pkg::RegPanelTop:    top_q        <= cfg_wdata_i;
        rcrs_pkg::RegPanelWidth:  width_q      <= cfg_wdata_i[rcrs_pkg::DimW-1:0];
        rcrs_pkg::RegPanelHeight: height_q     <= cfg_wdata_i[rcrs_pkg::DimW-1:0];
        rcrs_pkg::RegMinRadius:   min_radius_q <= cfg_wdata_i[rcrs_pkg::RadW-1:0];
        rcrs_pkg::RegDimAlpha:    alpha_q      <= cfg_wdata_i[rcrs_pkg::AlphaW-1:0];
        default: ;
      endcase
    end
  end

  // corner radius: max(min radius, width / 20), kept in a register
  assign width_prod = rcrs_pkg::ProdW'(width_q) * rcrs_pkg::ProdW'(rcrs_pkg::RadiusRecip);
  assign width_term = rcrs_pkg::RadW'(width_prod[rcrs_pkg::ProdW-1:rcrs_pkg::RecipShift]);
  assign radius_d   = (min_radius_q > width_term) ? min_radius_q : width_term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
    end else begin
      radius_q <= radius_d;
    end
  end

  always_comb begin
    cfg.panel_left   = left_q;
    cfg.panel_top    = top_q;
    cfg.panel_width  = width_q;
    cfg.panel_height = height_q;
    cfg.radius       = radius_q;
    cfg.dim_alpha    = alpha_q;
  end

  rcrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .push_i      (push_i),
    .row_index_i (row_index_i),
    .full_o      (full_o),
    .fq_push_o   (fq_push),
    .fq_item_o   (fq_din),
    .fq_full_i   (fq_full)
  );

  rcrs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .din_i   (fq_din),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .dout_o  (fq_dout),
    .empty_o (fq_empty)
  );

  rcrs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .fq_empty_i (fq_empty),
    .fq_item_i  (fq_dout),
    .fq_pop_o   (fq_pop),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_item_o (out_item),
    .status_o   (bk_status)
  );

  assign span_x_o     = $signed(out_item.span_x);
  assign span_y_o     = $signed(out_item.span_y);
  assign span_width_o = out_item.span_width;
  assign fill_alpha_o = out_item.fill_alpha;

  // waiting results never exceed the credit taken for them
  `RCRS_ASSERT_ALWAYS(a_count_within_credit, bk_status.out_count <= bk_status.credit,
                      "result count exceeds credit")
  // credit never overruns the result queue
  `RCRS_ASSERT_ALWAYS(a_credit_bound,
                      bk_status.credit <= rcrs_pkg::OutCntW'(rcrs_pkg::OutDepth),
                      "credit overflow")
  // a presented span always covers at least one pixel
  `RCRS_ASSERT_ALWAYS(a_width_nonzero, empty_o || (span_width_o != '0),
                      "zero width span presented")
  // a popped result releases its credit unless a new request is issued
  `RCRS_ASSERT_NEXT(a_pop_frees_credit, pop_i && !empty_o && fq_empty,
                    bk_status.credit < $past(bk_status.credit), "pop did not release credit")

endmodule

// ===== rtl/core/rcrs_queue.sv =====
module rcrs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rcrs_pkg::fq_item_t din_i,
  output logic               full_o,
  input  logic               pop_i,
  output rcrs_pkg::fq_item_t dout_o,
  output logic               empty_o
);

  rcrs_pkg::fq_item_t                    mem_q [rcrs_pkg::FqDepth];
  logic [rcrs_pkg::FqPtrW-1:0]           wr_ptr_q, wr_ptr_d;
  logic [rcrs_pkg::FqPtrW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [rcrs_pkg::FqCntW-1:0]           count_q, count_d;
  logic                                  do_push, do_pop;

  assign full_o  = (count_q == rcrs_pkg::FqCntW'(rcrs_pkg::FqDepth));
  assign empty_o = (count_q == '0);
  assign dout_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

// ===== rtl/core/rcrs_front.sv =====
module rcrs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rcrs_pkg::cfg_t                cfg_i,
  input  logic                          push_i,
  input  logic [rcrs_pkg::DimW-1:0]     row_index_i,
  output logic                          full_o,
  output logic                          fq_push_o,
  output rcrs_pkg::fq_item_t            fq_item_o,
  input  logic                          fq_full_i
);

  logic                          valid_q, valid_d;
  logic [rcrs_pkg::DimW-1:0]     row_q;
  logic                          in_panel, in_top, in_bottom;
  logic [rcrs_pkg::RadW-1:0]     dy_top, dy_bottom;
  logic [rcrs_pkg::DimW:0]       row_plus_r;

  // row classification against panel height and the corner bands
  assign in_panel   = (row_q < cfg_i.panel_height) &&
                      (32'(row_q) < 32'(rcrs_pkg::MaxPanelDim));
  assign in_top     = (row_q < rcrs_pkg::DimW'(cfg_i.radius));
  assign row_plus_r = (rcrs_pkg::DimW+1)'(row_q) + (rcrs_pkg::DimW+1)'(cfg_i.radius);
  assign in_bottom  = (row_plus_r >= (rcrs_pkg::DimW+1)'(cfg_i.panel_height));

  // distance from the nearest corner centre row; top band wins on overlap
  assign dy_top    = rcrs_pkg::RadW'(rcrs_pkg::DimW'(cfg_i.radius) - row_q);
  assign dy_bottom = rcrs_pkg::RadW'(row_plus_r - (rcrs_pkg::DimW+1)'(cfg_i.panel_height));

  always_comb begin
    fq_item_o.span_y = cfg_i.panel_top + rcrs_pkg::CoordW'(row_q);
    fq_item_o.band   = in_top | in_bottom;
    if (in_top) begin
      fq_item_o.dy = dy_top;
    end else if (in_bottom) begin
      fq_item_o.dy = dy_bottom;
    end else begin
      fq_item_o.dy = '0;
    end
  end

  // rows outside the panel are dropped here
  assign fq_push_o = valid_q & in_panel & ~fq_full_i;
  assign full_o    = valid_q & in_panel & fq_full_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i && !full_o) begin
      valid_d = 1'b1;
    end else if (!full_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      row_q <= row_index_i;
    end
  end

endmodule

// ===== rtl/core/rcrs_sqrt.sv =====
module rcrs_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [rcrs_pkg::SqW-1:0]    rad_i,
  input  rcrs_pkg::sq_side_t          side_i,
  output logic                        valid_o,
  output logic [rcrs_pkg::RadW-1:0]   root_o,
  output rcrs_pkg::sq_side_t          side_o
);

  localparam int N = rcrs_pkg::SqrtStages;

  // element 0 is the input, element i+1 the register after stage i
  logic                         st_valid [N+1];
  logic [rcrs_pkg::SqW-1:0]     st_rad   [N+1];
  logic [rcrs_pkg::RemW-1:0]    st_rem   [N+1];
  logic [rcrs_pkg::RadW-1:0]    st_root  [N+1];
  rcrs_pkg::sq_side_t           st_side  [N+1];

  assign st_valid[0] = valid_i;
  assign st_rad[0]   = rad_i;
  assign st_rem[0]   = '0;
  assign st_root[0]  = '0;
  assign st_side[0]  = side_i;

  // one root bit per stage, restoring digit recurrence
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [rcrs_pkg::RemW+1:0] rem2, trial;
    logic                      fits;

    assign rem2  = {st_rem[i], st_rad[i][rcrs_pkg::SqW-1 -: 2]};
    assign trial = (rcrs_pkg::RemW+2)'({st_root[i], 2'b01});
    assign fits  = (rem2 >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_valid[i+1] <= 1'b0;
      end else begin
        st_valid[i+1] <= st_valid[i];
      end
    end

    always_ff @(posedge clk_i) begin
      st_rad[i+1]  <= st_rad[i] << 2;
      st_rem[i+1]  <= fits ? rcrs_pkg::RemW'(rem2 - trial) : rcrs_pkg::RemW'(rem2);
      st_root[i+1] <= {st_root[i][rcrs_pkg::RadW-2:0], fits};
      st_side[i+1] <= st_side[i];
    end
  end

  assign valid_o = st_valid[N];
  assign root_o  = st_root[N];
  assign side_o  = st_side[N];

endmodule

// ===== rtl/core/rcrs_back.sv =====
module rcrs_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rcrs_pkg::cfg_t                  cfg_i,
  input  logic                            fq_empty_i,
  input  rcrs_pkg::fq_item_t              fq_item_i,
  output logic                            fq_pop_o,
  input  logic                            pop_i,
  output logic                            empty_o,
  output rcrs_pkg::out_item_t             out_item_o,
  output rcrs_pkg::bk_status_t            status_o
);

  // requests in flight plus results waiting, bounded by the result queue depth
  logic [rcrs_pkg::OutCntW-1:0] credit_q, credit_d;
  logic                         issue;

  // multiply stage
  logic                         m_valid_q;
  logic [rcrs_pkg::SqW-1:0]     m_rsq_q, m_dysq_q;
  rcrs_pkg::sq_side_t           m_side_q;

  // subtract stage
  logic                         a_valid_q;
  logic [rcrs_pkg::SqW-1:0]     a_arg_q;
  rcrs_pkg::sq_side_t           a_side_q;

  // square root output
  logic                         s_valid;
  logic [rcrs_pkg::RadW-1:0]    s_root;
  rcrs_pkg::sq_side_t           s_side;

  // span stage
  logic [rcrs_pkg::RadW-1:0]    x0;
  logic [rcrs_pkg::DimW+1:0]    diff;
  logic                         nonempty, wr_en, drop;
  rcrs_pkg::out_item_t          wr_item;

  // result queue
  rcrs_pkg::out_item_t          out_mem_q [rcrs_pkg::OutDepth];
  logic [rcrs_pkg::OutPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [rcrs_pkg::OutCntW-1:0] out_cnt_q, out_cnt_d;
  logic                         do_pop;

  assign issue    = ~fq_empty_i & (credit_q < rcrs_pkg::OutCntW'(rcrs_pkg::OutDepth));
  assign fq_pop_o = issue;

  // r*r and dy*dy, then r*r - dy*dy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      a_valid_q <= 1'b0;
    end else begin
      m_valid_q <= issue;
      a_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_rsq_q         <= rcrs_pkg::SqW'(cfg_i.radius) * rcrs_pkg::SqW'(cfg_i.radius);
    m_dysq_q        <= rcrs_pkg::SqW'(fq_item_i.dy) * rcrs_pkg::SqW'(fq_item_i.dy);
    m_side_q.span_y <= fq_item_i.span_y;
    m_side_q.band   <= fq_item_i.band;
    a_arg_q         <= m_rsq_q - m_dysq_q;
    a_side_q        <= m_side_q;
  end

  rcrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_valid_q),
    .rad_i   (a_arg_q),
    .side_i  (a_side_q),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  // inset and width; empty spans are dropped
  assign x0       = s_side.band ? (cfg_i.radius - s_root) : '0;
  assign diff     = (rcrs_pkg::DimW+2)'(cfg_i.panel_width) - (rcrs_pkg::DimW+2)'({x0, 1'b0});
  assign nonempty = ~diff[rcrs_pkg::DimW+1] & (diff != '0);
  assign wr_en    = s_valid & nonempty;
  assign drop     = s_valid & ~nonempty;

  always_comb begin
    wr_item.span_x     = cfg_i.panel_left + rcrs_pkg::CoordW'(x0);
    wr_item.span_y     = s_side.span_y;
    wr_item.span_width = diff[rcrs_pkg::DimW-1:0];
    wr_item.fill_alpha = cfg_i.dim_alpha;
  end

  // result queue
  assign empty_o    = (out_cnt_q == '0);
  assign do_pop     = pop_i & ~empty_o;
  assign out_item_o = out_mem_q[rd_ptr_q];

  // a pop and a drop in the same cycle each give back one credit
  always_comb begin
    case ({wr_en, do_pop})
      2'b10:   out_cnt_d = out_cnt_q + 1'b1;
      2'b01:   out_cnt_d = out_cnt_q - 1'b1;
      default: out_cnt_d = out_cnt_q;
    endcase
    credit_d = credit_q + rcrs_pkg::OutCntW'(issue) - rcrs_pkg::OutCntW'(do_pop)
               - rcrs_pkg::OutCntW'(drop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      out_cnt_q <= '0;
      credit_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      out_cnt_q <= out_cnt_d;
      credit_q  <= credit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      out_mem_q[wr_ptr_q] <= wr_item;
    end
  end

  assign status_o.credit    = credit_q;
  assign status_o.out_count = out_cnt_q;

endmodule

// ===== tb/rounded_corner_row_span_tb.sv =====
`timescale 1ns / 100ps

module rounded_corner_row_span_tb;

  localparam int SettleCycles = 24;
  localparam int SpanPhases   = 8;
  localparam int RowsPerPhase = 55;
  // Index past the register list; writes to it must change nothing
  localparam logic [rcrs_pkg::CfgIdxW-1:0] RegNone = 3'd7;

  // Predicts the span of each row and holds the spans still owed by the block
  class span_scoreboard;
    int panel_left;
    int panel_top;
    int panel_width;
    int panel_height;
    int min_radius;
    int dim_alpha;
    rcrs_pkg::out_item_t spans[$];
    int rows_noted;
    int blank_rows;
    int checked;
    int mismatches;

    function new();
      panel_left   = 0;
      panel_top    = 0;
      panel_width  = 1;
      panel_height = 1;
      min_radius   = 0;
      dim_alpha    = 0;
    endfunction

    function void set_reg(logic [rcrs_pkg::CfgIdxW-1:0] idx,
                          logic [rcrs_pkg::CfgDataW-1:0] data);
      case (idx)
        rcrs_pkg::RegPanelLeft:   panel_left   = int'($signed(data));
        rcrs_pkg::RegPanelTop:    panel_top    = int'($signed(data));
        rcrs_pkg::RegPanelWidth:  panel_width  = int'(data[rcrs_pkg::DimW-1:0]);
        rcrs_pkg::RegPanelHeight: panel_height = int'(data[rcrs_pkg::DimW-1:0]);
        rcrs_pkg::RegMinRadius:   min_radius   = int'(data[rcrs_pkg::RadW-1:0]);
        rcrs_pkg::RegDimAlpha:    dim_alpha    = int'(data[rcrs_pkg::AlphaW-1:0]);
        default: ;
      endcase
    endfunction

    function int radius();
      int q;
      q = panel_width / rcrs_pkg::RadiusDivisor;
      return (min_radius > q) ? min_radius : q;
    endfunction

    // Floor square root, one root bit at a time from the top
    function int floor_root(int v);
      int root;
      int trial;
      root = 0;
      for (int b = rcrs_pkg::RadW; b >= 0; b--) begin
        trial = root | (1 << b);
        if (longint'(trial) * trial <= v) root = trial;
      end
      return root;
    endfunction

    function void note_row(int row);
      int r, x0, x1, cy, dy, arg;
      rcrs_pkg::out_item_t span;
      rows_noted++;
      if (row >= panel_height || row >= rcrs_pkg::MaxPanelDim) begin
        blank_rows++;
        return;
      end
      r  = radius();
      x0 = 0;
      x1 = panel_width;
      // Corner bands: top band wins when the radius overlaps the bottom
      if (row < r || row >= panel_height - r) begin
        cy  = (row < r) ? r : panel_height - r;
        dy  = row - cy;
        arg = r * r - dy * dy;
        if (arg < 0) arg = 0;
        x0 = r - floor_root(arg);
        x1 = panel_width - r + floor_root(arg);
      end
      if (x1 <= x0) begin
        blank_rows++;
        return;
      end
      span.span_x     = rcrs_pkg::CoordW'(panel_left + x0);
      span.span_y     = rcrs_pkg::CoordW'(panel_top + row);
      span.span_width = rcrs_pkg::DimW'(x1 - x0);
      span.fill_alpha = rcrs_pkg::AlphaW'(dim_alpha);
      spans.insert(spans.size(), span);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_span(rcrs_pkg::out_item_t got);
      rcrs_pkg::out_item_t want;
      string diff;
      if (spans.size() == 0) begin
        flag($sformatf("span with no row owing it: x %0d y %0d width %0d alpha %0d",
                       $signed(got.span_x), $signed(got.span_y), got.span_width,
                       got.fill_alpha));
        return;
      end
      want = spans.pop_front();
      checked++;
      diff = "";
      if (got.span_x !== want.span_x)
        diff = {diff, $sformatf(" x exp %0d got %0d", $signed(want.span_x),
                                $signed(got.span_x))};
      if (got.span_y !== want.span_y)
        diff = {diff, $sformatf(" y exp %0d got %0d", $signed(want.span_y),
                                $signed(got.span_y))};
      if (got.span_width !== want.span_width)
        diff = {diff, $sformatf(" width exp %0d got %0d", want.span_width,
                                got.span_width)};
      if (got.fill_alpha !== want.fill_alpha)
        diff = {diff, $sformatf(" alpha exp %0d got %0d", want.fill_alpha,
                                got.fill_alpha)};
      if (diff != "") flag({"span mismatch:", diff});
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [rcrs_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [rcrs_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                          push_i = 1'b0;
  logic                          full_o;
  logic [rcrs_pkg::DimW-1:0]     row_index_i = '0;
  logic                          empty_o;
  logic                          pop_i = 1'b0;
  logic signed [rcrs_pkg::CoordW-1:0] span_x_o;
  logic signed [rcrs_pkg::CoordW-1:0] span_y_o;
  logic [rcrs_pkg::DimW-1:0]     span_width_o;
  logic [rcrs_pkg::AlphaW-1:0]   fill_alpha_o;

  span_scoreboard sb = new();
  bit feed_idle_en  = 1'b1;
  bit drain_idle_en = 1'b1;
  int settings_applied;

  rounded_corner_row_span DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_i       (push_i),
    .full_o       (full_o),
    .row_index_i  (row_index_i),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .span_x_o     (span_x_o),
    .span_y_o     (span_y_o),
    .span_width_o (span_width_o),
    .fill_alpha_o (fill_alpha_o)
  );

  always #5 clk_i = ~clk_i;

  // Result side: pop with random stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        pop_i <= 1'b0;
        stall_left--;
      end else if (drain_idle_en && $urandom_range(0, 4) == 0) begin
        pop_i <= 1'b0;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  // Accepted spans go straight to the checker
  always @(posedge clk_i) begin
    rcrs_pkg::out_item_t got;
    if (rst_ni && pop_i && !empty_o) begin
      got.span_x     = span_x_o;
      got.span_y     = span_y_o;
      got.span_width = span_width_o;
      got.fill_alpha = fill_alpha_o;
      sb.check_span(got);
    end
  end

  // Register write, one per cycle; call at a falling edge
  task automatic write_reg(input logic [rcrs_pkg::CfgIdxW-1:0] idx,
                           input logic [rcrs_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Full panel setting; spare upper data bits of the narrow registers carry noise
  task automatic load_panel(input int lft, input int tp, input int w, input int h,
                            input int mr, input int a);
    write_reg(rcrs_pkg::RegPanelLeft, rcrs_pkg::CfgDataW'(lft));
    write_reg(rcrs_pkg::RegPanelTop, rcrs_pkg::CfgDataW'(tp));
    write_reg(rcrs_pkg::RegPanelWidth, {4'($urandom), rcrs_pkg::DimW'(w)});
    write_reg(rcrs_pkg::RegPanelHeight, {4'($urandom), rcrs_pkg::DimW'(h)});
    write_reg(rcrs_pkg::RegMinRadius, {5'($urandom), rcrs_pkg::RadW'(mr)});
    write_reg(rcrs_pkg::RegDimAlpha, {8'($urandom), rcrs_pkg::AlphaW'(a)});
    cfg_we_i <= 1'b0;
    settings_applied++;
    repeat (4) @(negedge clk_i);
  endtask

  // Push a list of rows with optional random gaps; starts and ends at a falling edge
  task automatic feed_rows(input int rows[$]);
    foreach (rows[i]) begin
      if (feed_idle_en && $urandom_range(0, 3) == 0) begin
        push_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      push_i      <= 1'b1;
      row_index_i <= rcrs_pkg::DimW'(rows[i]);
      do @(posedge clk_i); while (full_o);
      sb.note_row(rows[i]);
      @(negedge clk_i);
    end
    push_i <= 1'b0;
  endtask

  // Wait out every owed span plus the pipeline depth for rows that give nothing
  task automatic settle();
    while (sb.spans.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Rows biased toward the corner bands of the current panel, some from the whole row range
  function automatic int pick_row();
    int r = sb.radius();
    int h = sb.panel_height;
    int band = (r < h) ? r : h;
    int lo = (h - r > 0) ? h - r : 0;
    int k = $urandom_range(0, 19);
    if (k < 3) return $urandom_range(0, rcrs_pkg::MaxPanelDim - 1);
    if (k < 10 && band > 0) return $urandom_range(0, band - 1);
    if (k < 16 && band > 0) return $urandom_range(lo, h - 1);
    return $urandom_range(0, h - 1);
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 5))
      0: return $urandom_range(1, 40);
      1: return ($urandom_range(0, 1) != 0) ? rcrs_pkg::MaxPanelDim - 1 : 1;
      2: return $urandom_range(1, 300);
      default: return $urandom_range(1, rcrs_pkg::MaxPanelDim - 1);
    endcase
  endfunction

  initial begin
    int rows[$];
    int w, h, mr;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset panel is one pixel: row 0 spans it, rows past the height give nothing
    rows = '{0, 1, rcrs_pkg::MaxPanelDim - 1};
    feed_rows(rows);
    settle();

    // Ignored register index, then the largest panel placed so coordinates wrap
    write_reg(RegNone, '1);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    load_panel(32767, 32760, rcrs_pkg::MaxPanelDim - 1, rcrs_pkg::MaxPanelDim - 1, 0, 255);
    rows = '{0, 1, 100, 204, 2047, 3890, 4094, 4095};
    feed_rows(rows);
    settle();

    // Radius far wider than the panel: corner rows collapse to nothing
    load_panel(-32768, -32768, 10, rcrs_pkg::MaxPanelDim - 1, (1 << rcrs_pkg::RadW) - 1, 0);
    rows = '{0, 2047, 3000, 4094};
    feed_rows(rows);
    settle();

    // Radius beyond the height, so every row of the panel falls in the top band
    load_panel(5, -3, 60, 8, 30, 128);
    rows = '{0, 3, 7, 8};
    feed_rows(rows);
    settle();

    // Random panels, the last one with both sides running flat out
    for (int p = 0; p < SpanPhases; p++) begin
      w = pick_dim();
      h = pick_dim();
      case ($urandom_range(0, 4))
        0: mr = 0;
        1: mr = $urandom_range(1, w / 2 + 1);
        2: mr = ($urandom_range(0, 3) == 0) ? (1 << rcrs_pkg::RadW) - 1 :
                                               $urandom_range(0, 64);
        default: mr = $urandom_range(0, 200);
      endcase
      load_panel($urandom_range(0, 65535), $urandom_range(0, 65535), w, h, mr,
                 $urandom_range(0, 255));
      if (p == SpanPhases - 1) begin
        feed_idle_en  = 1'b0;
        drain_idle_en = 1'b0;
      end else begin
        feed_idle_en  = ($urandom_range(0, 3) != 0);
        drain_idle_en = ($urandom_range(0, 3) != 0);
      end
      rows.delete();
      repeat (RowsPerPhase) rows.insert(rows.size(), pick_row());
      feed_rows(rows);
      settle();
    end

    $display("rows requested %0d, spans checked %0d, rows with no span %0d",
             sb.rows_noted, sb.checked, sb.blank_rows);
    $display("panel settings used %0d, mismatching or unowed spans %0d",
             settings_applied, sb.mismatches);
    if (sb.mismatches == 0 && sb.spans.size() == 0) begin
      $display("rounded_corner_row_span_tb: clean");
    end else begin
      $display("rounded_corner_row_span_tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d spans still owed", sb.spans.size());
    $display("rounded_corner_row_span_tb: errors");
    $finish;
  end

endmodule
